// ===== rtl/lttceb_pkg.sv =====
// Shared types and constants of the lidar TTC emergency brake block.
// No dependencies; imported by the front, back and top modules of the block.
package lttceb_pkg;

  localparam int MAX_BEAMS_DEF   = 4096;
  localparam int COS_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH     = 4;

  localparam int BRAKE_BEAM_W = 12;
  localparam int UA_W         = 22;   // beams that pass the FOV check fit here

  localparam longint unsigned PI_URAD = 64'd3141593;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam logic signed [24:0] ANGLE_SAT = 25'sd8388607;

  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_BEAM  = 1'b1;

  localparam logic signed [22:0] ANGLE_START_RST = -23'sd2356194;
  localparam logic [16:0] ANGLE_STEP_RST = 17'd4363;
  localparam logic [21:0] HALF_FOV_RST   = 22'd350000;
  localparam logic [13:0] TTC_LIMIT_RST  = 14'd500;

  typedef enum logic [1:0] {
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_HALF_FOV,
    REG_TTC_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] speed_mm_s;
    logic [15:0]        beam_range_mm;
    logic               beam_finite;
    logic               last_beam;
  } in_item_t;

  typedef struct packed {
    logic                    brake;
    logic [BRAKE_BEAM_W-1:0] brake_beam;
  } out_item_t;

  typedef struct packed {
    logic signed [22:0] angle_start_urad;
    logic [16:0]        angle_step_urad;
    logic [21:0]        half_fov_urad;
    logic [13:0]        ttc_limit_ms;
  } cfg_t;

endpackage

// ===== rtl/lttceb_fifo.sv =====
// Small register queue between the front and back parts.
// Depends on nothing outside itself.
module lttceb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count < CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/lttceb_front.sv =====
// Front part: takes input items, tracks speed, beam angle and beam index,
// and queues one entry per beam. Uses lttceb_pkg.
module lttceb_front import lttceb_pkg::*; #(
  parameter int MAX_BEAMS = MAX_BEAMS_DEF,
  parameter int BI_W      = $clog2(MAX_BEAMS),
  parameter int ENTRY_W   = 1 + 1 + UA_W + 16 + 16 + BI_W
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  in_item_t           item,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  typedef struct packed {
    logic               eval;
    logic               last;
    logic [UA_W-1:0]    ua;
    logic signed [15:0] speed;
    logic [15:0]        range_mm;
    logic [BI_W-1:0]    index;
  } entry_t;

  logic signed [15:0] current_speed;
  logic signed [23:0] beam_angle;
  logic [BI_W-1:0]    beam_index;

  logic               accept;
  logic signed [23:0] angle;
  logic [23:0]        ua;
  logic signed [24:0] angle_sum;
  logic               eval;
  entry_t             entry;

  assign item_ready = push_ready;
  assign accept     = item_valid && item_ready;
  assign push_valid = accept && (item.kind == KIND_BEAM);

  always_comb begin
    angle = (beam_index == '0) ?
            {cfg.angle_start_urad[22], cfg.angle_start_urad} : beam_angle;
    ua    = angle[23] ? 24'(-angle) : 24'(angle);
    eval  = item.beam_finite && (ua <= {2'b00, cfg.half_fov_urad});
    angle_sum = {angle[23], angle} + $signed({8'b0, cfg.angle_step_urad});
    entry.eval     = eval;
    entry.last     = item.last_beam;
    entry.ua       = ua[UA_W-1:0];   // beams past UA_W bits fail the FOV check
    entry.speed    = current_speed;
    entry.range_mm = item.beam_range_mm;
    entry.index    = beam_index;
  end

  assign push_data = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_speed <= '0;
      beam_index    <= '0;
    end else if (accept) begin
      if (item.kind == KIND_SPEED) begin
        current_speed <= item.speed_mm_s;
      end else if (item.last_beam) begin
        beam_index <= '0;
      end else if (beam_index < BI_W'(MAX_BEAMS - 1)) begin
        beam_index <= beam_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.kind == KIND_BEAM)) begin
      beam_angle <= (angle_sum > ANGLE_SAT) ? 24'(ANGLE_SAT) : angle_sum[23:0];
    end
  end

endmodule

// ===== rtl/lttceb_back.sv =====
// Back part: pipeline from beam angle to cosine index, cosine lookup,
// closing speed, TTC compare, brake latch and result register. Uses lttceb_pkg.
module lttceb_back import lttceb_pkg::*; #(
  parameter int MAX_BEAMS         = MAX_BEAMS_DEF,
  parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEF,
  parameter int BI_W              = $clog2(MAX_BEAMS),
  parameter int ENTRY_W           = 1 + 1 + UA_W + 16 + 16 + BI_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [13:0]        ttc_limit_ms,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               result_valid,
  input  logic               result_ready,
  output out_item_t          result
);

  typedef struct packed {
    logic               eval;
    logic               last;
    logic [UA_W-1:0]    ua;
    logic signed [15:0] speed;
    logic [15:0]        range_mm;
    logic [BI_W-1:0]    index;
  } entry_t;

  localparam int N1     = COS_TABLE_ENTRIES - 1;
  localparam int IDX_W  = $clog2(COS_TABLE_ENTRIES);
  localparam int HALF   = N1 / 2;
  localparam int HALF_W = $clog2(HALF + 1);
  localparam int NUM_W  = UA_W + IDX_W;
  localparam int RCP_W  = IDX_W + 1;
  localparam int Q_W    = IDX_W + 1;
  localparam logic [63:0] RECIP_64 = (64'd1 << NUM_W) / PI_URAD;
  localparam logic [RCP_W-1:0] RECIP = RECIP_64[RCP_W-1:0];
  localparam logic [NUM_W-1:0] PI_N   = NUM_W'(PI_URAD);
  localparam logic [NUM_W-1:0] HALF_PI = NUM_W'(PI_URAD / 2);

  // Half cosine table in Q1.14, magnitudes; the upper half is mirrored.
  logic [14:0] cos_tab [HALF + 1];

  for (genvar k = 0; k <= HALF; k++) begin : g_cos
    localparam longint unsigned ONE = 64'd1 << 30;
    localparam longint unsigned X   = (64'(k) * PI_Q30) / N1;
    localparam longint unsigned X2  = (X * X) >> 30;
    localparam longint unsigned T1  = ((ONE * X2) >> 30) / 2;
    localparam longint unsigned T2  = ((T1 * X2) >> 30) / 12;
    localparam longint unsigned T3  = ((T2 * X2) >> 30) / 30;
    localparam longint unsigned T4  = ((T3 * X2) >> 30) / 56;
    localparam longint unsigned T5  = ((T4 * X2) >> 30) / 90;
    localparam longint unsigned T6  = ((T5 * X2) >> 30) / 132;
    localparam longint unsigned T7  = ((T6 * X2) >> 30) / 182;
    localparam longint S = longint'(ONE) - longint'(T1) + longint'(T2) - longint'(T3)
                         + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint SC = (S < 0) ? 64'sd0 : S;
    localparam longint RV = (SC + 64'sd32768) >>> 16;
    assign cos_tab[k] = 15'(RV);
  end

  logic       adv;
  logic [7:1] vld;
  entry_t     m [1:7];
  entry_t     head;

  logic [NUM_W-1:0]       s1_num;
  logic [NUM_W-1:0]       s2_num;
  logic [Q_W-1:0]         s2_q0;
  logic [NUM_W-1:0]       s3_num;
  logic [Q_W-1:0]         s3_q0;
  logic [NUM_W-1:0]       s3_qp;
  logic [IDX_W-1:0]       s4_idx;
  logic [14:0]            s5_mag;
  logic                   s5_neg;
  logic signed [30:0]     s6_closing;
  logic [25:0]            s6_lhs;
  logic [25:0]            s7_lhs;
  logic [43:0]            s7_rhs;
  logic                   s7_pos;

  logic                   brake_found;
  logic [BI_W-1:0]        trigger_index;

  logic [NUM_W+RCP_W-1:0] recip_prod;
  logic [NUM_W-1:0]       rem;
  logic [Q_W:0]           q_fix;
  logic [IDX_W-1:0]       idx;
  logic                   upper;
  logic [IDX_W-1:0]       j;
  logic signed [15:0]     cos_s;
  logic signed [31:0]     closing_full;
  logic                   hit;
  logic                   found_now;
  logic [BI_W-1:0]        trig_now;
  logic [BI_W+BRAKE_BEAM_W-1:0] trig_ext;

  assign adv       = !result_valid || result_ready;
  assign pop_ready = adv;
  assign head      = pop_data;

  always_comb begin
    recip_prod = (NUM_W + RCP_W)'(s1_num) * (NUM_W + RCP_W)'(RECIP);
    rem   = s3_num - s3_qp;
    q_fix = (Q_W + 1)'(s3_q0) + (Q_W + 1)'(rem >= PI_N);
    idx   = (q_fix > (Q_W + 1)'(N1)) ? IDX_W'(N1) : q_fix[IDX_W-1:0];
    upper = (s4_idx > IDX_W'(HALF));
    j     = upper ? IDX_W'(N1) - s4_idx : s4_idx;
    cos_s = s5_neg ? -$signed({1'b0, s5_mag}) : $signed({1'b0, s5_mag});
    closing_full = m[5].speed * cos_s;
    hit = m[7].eval && s7_pos && ({4'b0, s7_lhs, 14'b0} < s7_rhs);
    found_now = brake_found || hit;
    trig_now  = brake_found ? trigger_index : m[7].index;
    trig_ext  = {{BRAKE_BEAM_W{1'b0}}, trig_now};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      brake_found   <= 1'b0;
      trigger_index <= '0;
      result_valid  <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[6:1], pop_valid};
      result_valid <= vld[7] && m[7].last;
      if (vld[7]) begin
        if (m[7].last) begin
          brake_found   <= 1'b0;
          trigger_index <= '0;
        end else begin
          brake_found   <= found_now;
          trigger_index <= trig_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[1] <= head;
      for (int s = 2; s <= 7; s++) begin
        m[s] <= m[s-1];
      end
      s1_num     <= NUM_W'(head.ua) * NUM_W'(N1) + HALF_PI;
      s2_num     <= s1_num;
      s2_q0      <= recip_prod[NUM_W +: Q_W];
      s3_num     <= s2_num;
      s3_q0      <= s2_q0;
      s3_qp      <= NUM_W'(s2_q0) * PI_N;
      s4_idx     <= idx;
      s5_mag     <= cos_tab[j[HALF_W-1:0]];
      s5_neg     <= upper;
      s6_closing <= closing_full[30:0];
      s6_lhs     <= 26'(m[5].range_mm) * 26'd1000;
      s7_lhs     <= s6_lhs;
      s7_rhs     <= 44'(ttc_limit_ms) * 44'(s6_closing[29:0]);
      s7_pos     <= (s6_closing > 31'sd0);
      if (vld[7] && m[7].last) begin
        result.brake      <= found_now;
        result.brake_beam <= found_now ? trig_ext[BRAKE_BEAM_W-1:0] : '0;
      end
    end
  end

endmodule

// ===== rtl/lidar_ttc_emergency_brake_unit.sv =====
// Lidar time-to-collision emergency brake, top level.
//
// Input channel (item_valid/item_ready/item) carries speed updates and lidar
// beams. Speed updates only refresh the stored forward speed. Each beam is
// checked against the field of view, and closing speed speed*cos(angle)
// from a Q1.14 table is compared against range over the TTC limit.
// The last beam of a scan produces one result (result_valid/result_ready/
// result): the brake flag and the index of the first braking beam.
// Users must write the APB registers only while the block is idle; not enforced.
//
// Throughput: one item per cycle while the four-entry queue has room; the back
// pipeline has seven stages and takes one beam per cycle while results are taken.
// Reset clears the speed, beam index, brake latch, queue and pipeline and
// loads the register defaults. When the result receiver stalls, the whole
// back pipeline holds; the queue absorbs up to four beams, then item_ready
// drops until the result is taken.
// Uses lttceb_pkg, lttceb_front, lttceb_fifo and lttceb_back.
module lidar_ttc_emergency_brake_unit import lttceb_pkg::*; #(
  parameter int MAX_BEAMS         = MAX_BEAMS_DEF,
  parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result
);

  localparam int BI_W    = $clog2(MAX_BEAMS);
  localparam int ENTRY_W = 1 + 1 + UA_W + 16 + 16 + BI_W;

  cfg_t             cfg;
  reg_idx_t         reg_sel;
  logic             push_valid;
  logic             push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start_urad <= ANGLE_START_RST;
      cfg.angle_step_urad  <= ANGLE_STEP_RST;
      cfg.half_fov_urad    <= HALF_FOV_RST;
      cfg.ttc_limit_ms     <= TTC_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_ANGLE_START: cfg.angle_start_urad <= pwdata[22:0];
        REG_ANGLE_STEP:  cfg.angle_step_urad  <= pwdata[16:0];
        REG_HALF_FOV:    cfg.half_fov_urad    <= pwdata[21:0];
        REG_TTC_LIMIT:   cfg.ttc_limit_ms     <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ANGLE_START: prdata = {{9{cfg.angle_start_urad[22]}}, cfg.angle_start_urad};
      REG_ANGLE_STEP:  prdata = {15'b0, cfg.angle_step_urad};
      REG_HALF_FOV:    prdata = {10'b0, cfg.half_fov_urad};
      REG_TTC_LIMIT:   prdata = {18'b0, cfg.ttc_limit_ms};
      default:         prdata = '0;
    endcase
  end

  lttceb_front #(
    .MAX_BEAMS (MAX_BEAMS),
    .BI_W      (BI_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lttceb_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lttceb_back #(
    .MAX_BEAMS         (MAX_BEAMS),
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
    .BI_W              (BI_W),
    .ENTRY_W           (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ttc_limit_ms (cfg.ttc_limit_ms),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
